>>> src/tlvf_pkg.sv
// tlvf_pkg: shared types, codes and helpers for the tlv tag occurrence finder
// no dependencies; used by every module under src
package tlvf_pkg;

	localparam int unsigned CFG_IDX_W = 1;
	localparam int unsigned CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_TARGET_TAG = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_OCCURRENCE = 1'd1;

	localparam logic [15:0] TARGET_TAG_RST = 16'h0000;
	localparam logic [7:0] OCCURRENCE_RST = 8'd1;

	localparam logic [2:0] PH_TAG1 = 3'd0;
	localparam logic [2:0] PH_TAG2 = 3'd1;
	localparam logic [2:0] PH_LEN1 = 3'd2;
	localparam logic [2:0] PH_LEN2 = 3'd3;
	localparam logic [2:0] PH_LEN2M = 3'd4;
	localparam logic [2:0] PH_SKIP = 3'd5;
	localparam logic [2:0] PH_COPY = 3'd6;

	localparam logic [1:0] ST_VALUE = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;
	localparam logic [1:0] ST_TRUNC = 2'd3;

	localparam logic [4:0] TAG_MULTI_MASK = 5'h1F;
	localparam logic [7:0] LEN_LONG_ONE = 8'h81;
	localparam logic [15:0] CONS_BIT_TWO = 16'h2000;
	localparam logic [15:0] CONS_BIT_ONE = 16'h0020;
	localparam logic [7:0] COUNT_MAX = 8'hFF;

	typedef struct packed {
		logic [7:0] data_byte;
		logic last_byte;
	} item_t;

	typedef struct packed {
		logic [7:0] value_byte;
		logic [7:0] value_length;
		logic [1:0] status;
		logic last;
	} result_t;

	function automatic logic tag_constructed(input logic [15:0] t);
		logic res;
		if (t[12:8] == TAG_MULTI_MASK) begin
			res = (t & CONS_BIT_TWO) != 16'h0000;
		end else begin
			res = (t & CONS_BIT_ONE) != 16'h0000;
		end
		return res;
	endfunction

endpackage

>>> src/tlvf_walker.sv
// tlvf_walker: ber-tlv walk state and per-word next-state logic
// depends on tlvf_pkg
module tlvf_walker (
	input logic clk,
	input logic arst_n,
	input logic step,
	input tlvf_pkg::item_t item,
	input logic [15:0] target_tag,
	input logic [7:0] occurrence,
	output logic res_valid,
	output tlvf_pkg::result_t res
);

	logic [2:0] phase_q, phase_n;
	logic [15:0] tag_q, tag_n;
	logic [7:0] cnt_q, cnt_n;
	logic [7:0] rem_q, rem_n;
	logic [7:0] mlen_q, mlen_n;
	logic fin_q, fin_n;

	logic [7:0] cnt_inc;
	logic [7:0] rem_dec;
	logic tag_hit;
	logic tl_go;
	logic tl_match;
	logic copied;

	assign tag_hit = tag_q == target_tag;
	assign cnt_inc = (cnt_q == tlvf_pkg::COUNT_MAX) ? cnt_q : cnt_q + 8'd1;
	assign rem_dec = rem_q - 8'd1;

	always_comb begin
		phase_n = phase_q;
		tag_n = tag_q;
		cnt_n = cnt_q;
		rem_n = rem_q;
		mlen_n = mlen_q;
		fin_n = fin_q;
		res_valid = 1'b0;
		res = '0;
		copied = 1'b0;
		tl_go = 1'b0;
		tl_match = 1'b0;

		if (!fin_q) begin
			unique case (phase_q)
				tlvf_pkg::PH_TAG2: begin
					tag_n = tag_q | {8'h00, item.data_byte};
					phase_n = tlvf_pkg::PH_LEN1;
				end
				tlvf_pkg::PH_LEN1: begin
					if (tag_hit) begin
						cnt_n = cnt_inc;
					end
					if (item.data_byte == tlvf_pkg::LEN_LONG_ONE) begin
						if (tag_hit && cnt_inc == occurrence) begin
							mlen_n = 8'h00;
							phase_n = tlvf_pkg::PH_LEN2M;
						end else begin
							phase_n = tlvf_pkg::PH_LEN2;
						end
					end else begin
						tl_go = 1'b1;
						tl_match = tag_hit && cnt_inc == occurrence;
					end
				end
				tlvf_pkg::PH_LEN2: begin
					tl_go = 1'b1;
				end
				tlvf_pkg::PH_LEN2M: begin
					tl_go = 1'b1;
					tl_match = 1'b1;
				end
				tlvf_pkg::PH_SKIP: begin
					rem_n = rem_dec;
					if (rem_dec == 8'h00) begin
						phase_n = tlvf_pkg::PH_TAG1;
					end
				end
				tlvf_pkg::PH_COPY: begin
					rem_n = rem_dec;
					copied = 1'b1;
					res_valid = 1'b1;
					res.value_byte = item.data_byte;
					res.value_length = mlen_q;
					res.status = tlvf_pkg::ST_VALUE;
					res.last = rem_dec == 8'h00;
					if (rem_dec == 8'h00) begin
						fin_n = 1'b1;
					end
				end
				default: begin
					if (item.data_byte[4:0] == tlvf_pkg::TAG_MULTI_MASK) begin
						tag_n = {item.data_byte, 8'h00};
						phase_n = tlvf_pkg::PH_TAG2;
					end else begin
						tag_n = {8'h00, item.data_byte};
						phase_n = tlvf_pkg::PH_LEN1;
					end
				end
			endcase
		end

		// length field complete
		if (tl_go) begin
			if (tl_match) begin
				mlen_n = item.data_byte;
				if (item.data_byte == 8'h00) begin
					res_valid = 1'b1;
					res.value_byte = 8'h00;
					res.value_length = 8'h00;
					res.status = tlvf_pkg::ST_EMPTY;
					res.last = 1'b1;
					fin_n = 1'b1;
				end else begin
					rem_n = item.data_byte;
					phase_n = tlvf_pkg::PH_COPY;
				end
			end else if (tlvf_pkg::tag_constructed(tag_q) || item.data_byte == 8'h00) begin
				phase_n = tlvf_pkg::PH_TAG1;
			end else begin
				rem_n = item.data_byte;
				phase_n = tlvf_pkg::PH_SKIP;
			end
		end

		// end of response
		if (item.last_byte) begin
			if (!fin_n) begin
				res_valid = 1'b1;
				if (phase_n == tlvf_pkg::PH_COPY || phase_n == tlvf_pkg::PH_LEN2M) begin
					res.value_byte = copied ? item.data_byte : 8'h00;
					res.value_length = mlen_n;
					res.status = tlvf_pkg::ST_TRUNC;
				end else begin
					res.value_byte = 8'h00;
					res.value_length = 8'h00;
					res.status = tlvf_pkg::ST_NOT_FOUND;
				end
				res.last = 1'b1;
			end
			phase_n = tlvf_pkg::PH_TAG1;
			tag_n = 16'h0000;
			cnt_n = 8'h00;
			rem_n = 8'h00;
			mlen_n = 8'h00;
			fin_n = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= tlvf_pkg::PH_TAG1;
			tag_q <= 16'h0000;
			cnt_q <= 8'h00;
			rem_q <= 8'h00;
			mlen_q <= 8'h00;
			fin_q <= 1'b0;
		end else if (step) begin
			phase_q <= phase_n;
			tag_q <= tag_n;
			cnt_q <= cnt_n;
			rem_q <= rem_n;
			mlen_q <= mlen_n;
			fin_q <= fin_n;
		end
	end

endmodule

>>> src/tlvf_out_reg.sv
// tlvf_out_reg: result register on the output channel
// depends on tlvf_pkg
module tlvf_out_reg (
	input logic clk,
	input logic arst_n,
	input logic load,
	input tlvf_pkg::result_t res,
	input logic out_ready,
	output logic free,
	output logic out_valid,
	output logic [7:0] value_byte,
	output logic [7:0] value_length,
	output logic [1:0] status,
	output logic last
);

	logic valid_q;
	tlvf_pkg::result_t res_q;

	assign free = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

	assign out_valid = valid_q;
	assign value_byte = res_q.value_byte;
	assign value_length = res_q.value_length;
	assign status = res_q.status;
	assign last = res_q.last;

endmodule

>>> src/tlv_tag_occurrence_finder.sv
// tlv_tag_occurrence_finder: streaming ber-tlv tag search, top level
// each word is held in the input register; its result is registered in the output register and then offered
// throughput: one word per cycle, unless a result meets a full output register that is not being read
// reset: asynchronous; walk state idle, target_tag 0, occurrence 1, output empty
// depends on tlvf_pkg, tlvf_walker, tlvf_out_reg
module tlv_tag_occurrence_finder (
	input logic clk,
	input logic arst_n,
	input logic cfg_write,
	input logic [tlvf_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [tlvf_pkg::CFG_DATA_W-1:0] cfg_data,
	input logic in_valid,
	output logic in_ready,
	input logic [7:0] data_byte,
	input logic last_byte,
	output logic out_valid,
	input logic out_ready,
	output logic [7:0] value_byte,
	output logic [7:0] value_length,
	output logic [1:0] status,
	output logic last
);

	logic [15:0] target_tag_q;
	logic [7:0] occurrence_q;

	logic valid_s1;
	tlvf_pkg::item_t item_s1;

	logic adv_s1;
	logic res_valid;
	tlvf_pkg::result_t res;
	logic out_free;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_tag_q <= tlvf_pkg::TARGET_TAG_RST;
			occurrence_q <= tlvf_pkg::OCCURRENCE_RST;
		end else if (cfg_write) begin
			unique case (cfg_index)
				tlvf_pkg::CFG_TARGET_TAG: target_tag_q <= cfg_data;
				tlvf_pkg::CFG_OCCURRENCE: occurrence_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// input register
	assign adv_s1 = valid_s1 && (!res_valid || out_free);
	assign in_ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.data_byte <= data_byte;
			item_s1.last_byte <= last_byte;
		end
	end

	tlvf_walker u_walker (
		.clk(clk),
		.arst_n(arst_n),
		.step(adv_s1),
		.item(item_s1),
		.target_tag(target_tag_q),
		.occurrence(occurrence_q),
		.res_valid(res_valid),
		.res(res)
	);

	tlvf_out_reg u_out_reg (
		.clk(clk),
		.arst_n(arst_n),
		.load(adv_s1 && res_valid),
		.res(res),
		.out_ready(out_ready),
		.free(out_free),
		.out_valid(out_valid),
		.value_byte(value_byte),
		.value_length(value_length),
		.status(status),
		.last(last)
	);

	a_stall_only_on_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !in_ready) |-> (out_valid && !out_ready))
		else $error("input stalled without output backpressure");

	a_end_status_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status == tlvf_pkg::ST_NOT_FOUND || status == tlvf_pkg::ST_EMPTY))
		|-> last)
		else $error("terminal status without last");

	a_value_has_length: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == tlvf_pkg::ST_VALUE) |-> (value_length != 8'h00))
		else $error("value word with zero declared length");

	a_empty_has_no_length: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == tlvf_pkg::ST_EMPTY) |-> (value_length == 8'h00))
		else $error("empty match with nonzero length");

endmodule
